### rtl/whole_word_text_matcher_assert.svh
// ----------------------------------------------------------------------------
// Whole-word text matcher assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WHOLE_WORD_TEXT_MATCHER_ASSERT_SVH
`define WHOLE_WORD_TEXT_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WWTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wwtm assertion failed");
// next-cycle implication
`define WWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wwtm assertion failed");
`else
`define WWTM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WWTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/wwtm_pkg.sv
// ----------------------------------------------------------------------------
// Whole-word text matcher package
// Character constants, register indexes and character helper functions.
// ----------------------------------------------------------------------------
package wwtm_pkg;

    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_REG_W   = 5;

    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_char NEWLINE    = 8'h0A;
    localparam t_char UNDERSCORE = 8'h5F;
    localparam t_char DIGIT_0    = 8'h30;
    localparam t_char DIGIT_9    = 8'h39;
    localparam t_char UPPER_A    = 8'h41;
    localparam t_char UPPER_Z    = 8'h5A;
    localparam t_char LOWER_A    = 8'h61;
    localparam t_char LOWER_Z    = 8'h7A;
    localparam t_char CASE_DELTA = 8'h20;

    localparam t_cfg_idx CFG_PAT_LO     = 3'd0;
    localparam t_cfg_idx CFG_PAT_HI     = 3'd1;
    localparam t_cfg_idx CFG_PAT_LEN    = 3'd2;
    localparam t_cfg_idx CFG_MATCH_CASE = 3'd3;
    localparam t_cfg_idx CFG_WORD_BEGIN = 3'd4;
    localparam t_cfg_idx CFG_WHOLE_WORD = 3'd5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // fold A-Z to a-z unless an exact compare is asked for
    function automatic t_char fold_char(input t_char b, input logic exact);
        if (!exact && b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_DELTA;
        end
        return b;
    endfunction

    function automatic logic is_word_char(input t_char b);
        return (b >= DIGIT_0 && b <= DIGIT_9) || (b >= UPPER_A && b <= UPPER_Z) ||
               (b >= LOWER_A && b <= LOWER_Z) || (b == UNDERSCORE);
    endfunction

endpackage

### rtl/whole_word_text_matcher.sv
// A match result enters the result queue when its byte is accepted; o_out_valid is
// driven from the queue count. Throughput: one byte per cycle while o_in_stall is low;
// every pattern offset is compared in parallel against a shift window. A byte can give
// two results, absorbed by a four-entry result queue; input stalls at three or more entries.
// Reset (synchronous, active low): line 1, column 0, no pending candidate, queue empty,
// configuration registers to their reset values.
// ----------------------------------------------------------------------------
// Whole-word text matcher
// Streams text bytes and reports non-overlapping pattern matches with line and
// column, with optional case folding, word-begin and whole-word checks.
// ----------------------------------------------------------------------------
`include "whole_word_text_matcher_assert.svh"

module whole_word_text_matcher
    import wwtm_pkg::*;
#(
    parameter int PATTERN_MAX = 16,
    parameter int COLUMN_BITS = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // text in
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [CHAR_W-1:0]      i_char_code,
    input  logic                   i_end_of_text,
    // results out
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [LINE_BITS-1:0]   o_line_number,
    output logic [COLUMN_BITS-1:0] o_column,
    output logic                   o_last
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CB = COLUMN_BITS;

    // configuration registers
    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_REG_W-1:0]  r_pat_len;
    logic                  r_match_case;
    logic                  r_word_begin;
    logic                  r_whole_word;

    // scan state
    t_char                  r_recent [PATTERN_MAX];
    t_char                  n_recent [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_word_hist, n_word_hist;
    logic [CB-1:0]          r_line_col, n_line_col;
    logic [LINE_BITS-1:0]   r_line_cnt, n_line_cnt;
    logic [CB:0]            r_resume, n_resume;
    logic                   r_pend_vld, n_pend_vld;
    logic [CB-1:0]          r_pend_col, n_pend_col;

    // result queue
    logic [LINE_BITS-1:0]  r_fifo_line [FIFO_DEPTH];
    logic [CB-1:0]         r_fifo_col  [FIFO_DEPTH];
    logic                  r_fifo_last [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic                  in_acc;
    logic                  out_acc;
    logic [LW-1:0]         eff_len;
    t_char                 win [PATTERN_MAX];
    logic                  win_match;
    logic                  prev_word;
    logic                  cur_word;
    logic                  res0_vld, res1_vld;
    logic [CB-1:0]         res0_col, res1_col;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo     <= '0;
            r_pat_hi     <= '0;
            r_pat_len    <= LEN_REG_W'(1);
            r_match_case <= 1'b1;
            r_word_begin <= 1'b0;
            r_whole_word <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAT_LO:     r_pat_lo     <= i_cfg_data;
                CFG_PAT_HI:     r_pat_hi     <= i_cfg_data;
                CFG_PAT_LEN:    r_pat_len    <= i_cfg_data[LEN_REG_W-1:0];
                CFG_MATCH_CASE: r_match_case <= i_cfg_data[0];
                CFG_WORD_BEGIN: r_word_begin <= i_cfg_data[0];
                CFG_WHOLE_WORD: r_whole_word <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the pattern length into 1..PATTERN_MAX
    always_comb begin
        if (r_pat_len == '0) begin
            eff_len = LW'(1);
        end else if (r_pat_len > LEN_REG_W'(PATTERN_MAX)) begin
            eff_len = LW'(PATTERN_MAX);
        end else begin
            eff_len = r_pat_len[LW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // window compare: pattern byte i against window byte len-1-i
    // ------------------------------------------------------------------
    always_comb begin
        logic [2*CFG_DATA_W-1:0] pat_all;
        t_char                   sel;
        pat_all   = {r_pat_hi, r_pat_lo};
        win[0]    = i_char_code;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            win[k] = r_recent[k-1];
        end
        win_match = 1'b1;
        prev_word = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            sel = '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                if (LW'(k + i + 1) == eff_len) begin
                    sel = win[k];
                end
            end
            if (LW'(i) < eff_len &&
                fold_char(pat_all[8*i +: 8], r_match_case) != fold_char(sel, r_match_case)) begin
                win_match = 1'b0;
            end
            // flag of the byte just before the match start
            if (LW'(i + 1) == eff_len) begin
                prev_word = r_word_hist[i];
            end
        end
    end

    assign cur_word = is_word_char(i_char_code);

    // ------------------------------------------------------------------
    // next scan state and results for the byte on the input
    // ------------------------------------------------------------------
    always_comb begin
        logic [CB-1:0] col_p1;
        logic [CB-1:0] start;
        logic          word_ok;

        for (int k = 0; k < PATTERN_MAX; k++) begin
            n_recent[k] = r_recent[k];
        end
        n_word_hist = r_word_hist;
        n_line_col  = r_line_col;
        n_line_cnt  = r_line_cnt;
        n_resume    = r_resume;
        n_pend_vld  = r_pend_vld;
        n_pend_col  = r_pend_col;
        res0_vld    = 1'b0;
        res0_col    = r_pend_col;
        res1_vld    = 1'b0;
        res1_col    = '0;
        col_p1      = r_line_col + CB'(1);
        start       = col_p1 - CB'(eff_len);
        word_ok     = 1'b1;

        if (i_char_code == NEWLINE) begin
            res0_vld = r_pend_vld;
            if (r_line_cnt != '1) begin
                n_line_cnt = r_line_cnt + LINE_BITS'(1);
            end
            n_line_col  = '0;
            n_resume    = '0;
            n_pend_vld  = 1'b0;
            n_pend_col  = '0;
            n_word_hist = '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                n_recent[k] = '0;
            end
        end else begin
            // settle the candidate waiting on this byte
            if (r_pend_vld) begin
                if (cur_word) begin
                    n_resume = (CB+1)'(r_pend_col) + (CB+1)'(1);
                end else begin
                    res0_vld = 1'b1;
                    n_resume = (CB+1)'(r_pend_col) + (CB+1)'(eff_len);
                end
                n_pend_vld = 1'b0;
            end
            // a saturated column stops the scan for the rest of the line
            if (r_line_col != '1) begin
                n_recent[0] = i_char_code;
                for (int k = 1; k < PATTERN_MAX; k++) begin
                    n_recent[k] = r_recent[k-1];
                end
                n_word_hist = PATTERN_MAX'({r_word_hist, cur_word});
                n_line_col  = col_p1;
                if (col_p1 >= CB'(eff_len) && {1'b0, start} >= n_resume && win_match) begin
                    if ((r_word_begin || r_whole_word) && start != '0 && prev_word) begin
                        word_ok = 1'b0;
                    end
                    if (!word_ok) begin
                        n_resume = (CB+1)'(start) + (CB+1)'(1);
                    end else if (r_whole_word) begin
                        n_pend_vld = 1'b1;
                        n_pend_col = start;
                    end else begin
                        res1_vld = 1'b1;
                        res1_col = start;
                        n_resume = (CB+1)'(start) + (CB+1)'(eff_len);
                    end
                end
            end
            // end of text closes the line
            if (i_end_of_text && n_pend_vld) begin
                res1_vld = 1'b1;
                res1_col = n_pend_col;
            end
        end

        if (i_end_of_text) begin
            n_line_cnt  = LINE_BITS'(1);
            n_line_col  = '0;
            n_resume    = '0;
            n_pend_vld  = 1'b0;
            n_pend_col  = '0;
            n_word_hist = '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                n_recent[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_hist <= '0;
            r_line_col  <= '0;
            r_line_cnt  <= LINE_BITS'(1);
            r_resume    <= '0;
            r_pend_vld  <= 1'b0;
            r_pend_col  <= '0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_recent[k] <= '0;
            end
        end else if (in_acc) begin
            r_word_hist <= n_word_hist;
            r_line_col  <= n_line_col;
            r_line_cnt  <= n_line_cnt;
            r_resume    <= n_resume;
            r_pend_vld  <= n_pend_vld;
            r_pend_col  <= n_pend_col;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_recent[k] <= n_recent[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // result queue: up to two entries pushed per transaction
    // ------------------------------------------------------------------
    logic [FIFO_CNT_W-1:0] push_cnt;
    logic [FIFO_PTR_W-1:0] wr_next;

    assign push_cnt = in_acc ? (FIFO_CNT_W'(res0_vld) + FIFO_CNT_W'(res1_vld)) : '0;
    assign wr_next  = r_wr_ptr + FIFO_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (res0_vld) begin
                r_fifo_line[r_wr_ptr] <= r_line_cnt;
                r_fifo_col[r_wr_ptr]  <= res0_col;
                r_fifo_last[r_wr_ptr] <= !res1_vld;
                if (res1_vld) begin
                    r_fifo_line[wr_next] <= r_line_cnt;
                    r_fifo_col[wr_next]  <= res1_col;
                    r_fifo_last[wr_next] <= 1'b1;
                end
            end else if (res1_vld) begin
                r_fifo_line[r_wr_ptr] <= r_line_cnt;
                r_fifo_col[r_wr_ptr]  <= res1_col;
                r_fifo_last[r_wr_ptr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_cnt[FIFO_PTR_W-1:0];
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + push_cnt - FIFO_CNT_W'(out_acc);
        end
    end

    // hold off input unless two free slots remain
    assign o_in_stall    = r_count > FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign o_out_valid   = r_count != '0;
    assign o_line_number = r_fifo_line[r_rd_ptr];
    assign o_column      = r_fifo_col[r_rd_ptr];
    assign o_last        = r_fifo_last[r_rd_ptr];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `WWTM_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `WWTM_ASSERT_IMPLY(a_room_on_accept, i_clk, i_rst_n, in_acc, r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2))
    `WWTM_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, out_acc && !in_acc, r_count == $past(r_count) - FIFO_CNT_W'(1))
    `WWTM_ASSERT_IMPLY(a_line_nonzero, i_clk, i_rst_n, 1'b1, r_line_cnt != '0)
    `WWTM_ASSERT_NEXT(a_newline_clears, i_clk, i_rst_n, in_acc && i_char_code == NEWLINE, r_line_col == '0 && !r_pend_vld)

endmodule

### tb/whole_word_text_matcher_test.sv
// ----------------------------------------------------------------------------
// Whole-word text matcher testbench
// Streams text bytes into the matcher and checks every reported match, line
// and column against an in-bench prediction. Covers directed corner cases,
// randomized patterns and options, and output back-pressure.
// ----------------------------------------------------------------------------
module whole_word_text_matcher_test;
    import wwtm_pkg::*;

    localparam int PATTERN_MAX   = 16;
    localparam int COL_SAT       = 65535;
    localparam int LINE_SAT      = 24'hFF_FFFF;
    localparam int RANDOM_PHASES = 8;
    localparam int RANDOM_CHUNK  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        t_char code;
        logic  eot;
    } t_text_item;

    typedef struct packed {
        logic [23:0] line_no;
        logic [15:0] col;
        logic        is_last;
    } t_match;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [CHAR_W-1:0]     i_char_code   = '0;
    logic                  i_end_of_text = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [23:0]           o_line_number;
    logic [15:0]           o_column;
    logic                  o_last;

    whole_word_text_matcher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_line_number (o_line_number),
        .o_column      (o_column),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    t_text_item  text_q[$];
    t_match      match_expect_q[$];
    int          send_idle_pct   = 8;
    int          recv_idle_pct   = 68;
    logic        hold_arm        = 1'b0;
    int          hold_left;
    int unsigned cycle_count     = 0;
    int          mismatch_count  = 0;
    int          bytes_accepted  = 0;
    int          results_checked = 0;
    int          settings_used   = 0;

    // register copies
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len_reg;
    logic        exact_case;
    logic        word_begin_on;
    logic        whole_word_on;

    // matcher state
    t_char       win_bytes [PATTERN_MAX];
    int          col_now;
    int          line_now;
    int          resume_at;
    logic        held_valid;
    int          held_col;
    logic [31:0] word_bits;

    function automatic t_char fold_byte(input t_char b);
        if (!exact_case && b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_DELTA;
        end
        return b;
    endfunction

    function automatic logic word_byte(input t_char b);
        return (b >= DIGIT_0 && b <= DIGIT_9) || (b >= UPPER_A && b <= UPPER_Z) ||
               (b >= LOWER_A && b <= LOWER_Z) || (b == UNDERSCORE);
    endfunction

    function automatic int pat_len_eff();
        if (pat_len_reg == 0) begin
            return 1;
        end
        if (pat_len_reg > PATTERN_MAX) begin
            return PATTERN_MAX;
        end
        return pat_len_reg;
    endfunction

    function automatic t_char pat_byte(input int i);
        if (i < 8) begin
            return pat_lo[i*8 +: 8];
        end
        return pat_hi[(i-8)*8 +: 8];
    endfunction

    function automatic t_char pick_pattern_byte();
        case ($urandom_range(8))
            0: return LOWER_A;
            1: return "B";
            2: return UNDERSCORE;
            3: return "7";
            4: return " ";
            5: return "-";
            6: return 8'hFF;
            7: return 8'hC1;
            default: return t_char'($urandom_range(255));
        endcase
    endfunction

    task automatic clear_line();
        col_now    = 0;
        resume_at  = 0;
        held_valid = 1'b0;
        held_col   = 0;
        word_bits  = '0;
        win_bytes  = '{default: 8'h00};
    endtask

    task automatic push_match(input int col);
        t_match m;
        m.line_no = line_now[23:0];
        m.col     = col[15:0];
        m.is_last = 1'b0;
        match_expect_q = {match_expect_q, m};
    endtask

    // advance the matcher by one accepted byte and queue the results it causes
    task automatic predict_matches(input t_char b, input logic eot);
        int   len;
        int   first;
        int   s;
        logic w;
        logic ok;
        len   = pat_len_eff();
        first = match_expect_q.size();
        if (b == NEWLINE) begin
            if (held_valid) begin
                push_match(held_col);
            end
            if (line_now < LINE_SAT) begin
                line_now++;
            end
            clear_line();
        end else begin
            w = word_byte(fold_byte(b));
            if (held_valid) begin
                if (w) begin
                    resume_at = held_col + 1;
                end else begin
                    push_match(held_col);
                    resume_at = held_col + len;
                end
                held_valid = 1'b0;
            end
            // saturated column: the byte neither counts nor starts a candidate
            if (col_now < COL_SAT) begin
                for (int i = PATTERN_MAX - 1; i > 0; i--) begin
                    win_bytes[i] = win_bytes[i-1];
                end
                win_bytes[0] = b;
                word_bits    = {word_bits[30:0], w};
                col_now++;
                if (col_now >= len) begin
                    s  = col_now - len;
                    ok = 1'b1;
                    for (int i = 0; i < len; i++) begin
                        if (fold_byte(pat_byte(i)) != fold_byte(win_bytes[len-1-i])) begin
                            ok = 1'b0;
                        end
                    end
                    if (s >= resume_at && ok) begin
                        if ((word_begin_on || whole_word_on) && s > 0 && word_bits[len]) begin
                            resume_at = s + 1;
                        end else if (whole_word_on) begin
                            held_valid = 1'b1;
                            held_col   = s;
                        end else begin
                            push_match(s);
                            resume_at = s + len;
                        end
                    end
                end
            end
            if (eot && held_valid) begin
                push_match(held_col);
            end
        end
        if (eot) begin
            line_now = 1;
            clear_line();
        end
        if (match_expect_q.size() > first) begin
            match_expect_q[match_expect_q.size()-1].is_last = 1'b1;
        end
    endtask

    task automatic queue_byte(input t_char code, input logic eot);
        t_text_item item;
        item.code = code;
        item.eot  = eot;
        text_q = {text_q, item};
    endtask

    task automatic queue_text(input string s, input logic eot_last);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i], eot_last && (i == s.len() - 1));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_PAT_LO:     pat_lo        = data;
            CFG_PAT_HI:     pat_hi        = data;
            CFG_PAT_LEN:    pat_len_reg   = data[4:0];
            CFG_MATCH_CASE: exact_case    = data[0];
            CFG_WORD_BEGIN: word_begin_on = data[0];
            CFG_WHOLE_WORD: whole_word_on = data[0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len, input logic exact,
                                input logic wb, input logic ww);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(CFG_PAT_LO, lo);
        write_reg(CFG_PAT_HI, hi);
        write_reg(CFG_PAT_LEN, {junk[63:5], len});
        write_reg(CFG_MATCH_CASE, {junk[63:1], exact});
        write_reg(CFG_WORD_BEGIN, {junk[62:0], wb});
        write_reg(CFG_WHOLE_WORD, {junk[61:0], ww, 1'b0} >> 1 | ww);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        while (text_q.size() != 0 || i_in_valid || match_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // text driver
    always @(posedge i_clk) begin
        t_text_item item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_matches(i_char_code, i_end_of_text);
                bytes_accepted++;
            end
            // hold the payload while stalled
            if (!i_in_valid || !o_in_stall) begin
                if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = text_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_char_code   <= item.code;
                    i_end_of_text <= item.eot;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (match_expect_q.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result: line %0d col %0d last %0b",
                             o_line_number, o_column, o_last);
                end
                mismatch_count++;
            end else begin
                want = match_expect_q.pop_front();
                results_checked++;
                if (o_line_number !== want.line_no || o_column !== want.col ||
                    o_last !== want.is_last) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: expected line %0d col %0d last %0b, got line %0d col %0d last %0b",
                                 want.line_no, want.col, want.is_last,
                                 o_line_number, o_column, o_last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len_pick;
        int          queued;
        int          r;
        t_char       c;

        pat_lo        = '0;
        pat_hi        = '0;
        pat_len_reg   = 5'd1;
        exact_case    = 1'b1;
        word_begin_on = 1'b0;
        whole_word_on = 1'b0;
        line_now      = 1;
        clear_line();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one zero byte, exact compare
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(NEWLINE, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // folded compare, word-begin rejects the first candidate
        apply_config(64'h6261, 64'h0, 5'd2, 1'b0, 1'b1, 1'b0);
        queue_text("xAB aB", 1'b0);
        wait_drained();

        // zero length acts as one; whole word decided by end of text
        apply_config(64'h61, 64'h0, 5'd0, 1'b1, 1'b0, 1'b1);
        queue_text("_a a", 1'b1);
        wait_drained();

        // oversize length acts as sixteen, non-ASCII pattern bytes
        apply_config(64'hF7F6_F5F4_F3F2_F1F0, 64'hFFFE_FDFC_FBFA_F9F8, 5'd31,
                     1'b0, 1'b1, 1'b1);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            queue_byte(t_char'(8'hF0 + i), 1'b0);
        end
        queue_byte(".", 1'b1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 68;
                recv_idle_pct = 8;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 8; i++) begin
                lo[i*8 +: 8] = pick_pattern_byte();
                hi[i*8 +: 8] = pick_pattern_byte();
            end
            r = $urandom_range(99);
            if (r < 10) begin
                len_pick = 5'd0;
            end else if (r < 20) begin
                len_pick = 5'd16;
            end else if (r < 25) begin
                len_pick = 5'($urandom_range(31, 17));
            end else begin
                len_pick = 5'($urandom_range(4, 1));
            end
            // the text continues across the register change
            apply_config(lo, hi, len_pick, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            queued = 0;
            while (queued < RANDOM_CHUNK) begin
                r = $urandom_range(99);
                if (r < 35) begin
                    for (int i = 0; i < pat_len_eff(); i++) begin
                        c = pat_byte(i);
                        if (!exact_case && ((c >= UPPER_A && c <= UPPER_Z) ||
                            (c >= LOWER_A && c <= LOWER_Z)) && $urandom_range(1)) begin
                            c = c ^ CASE_DELTA;
                        end
                        queue_byte(c, 1'b0);
                    end
                    queued += pat_len_eff();
                end else begin
                    if (r < 60) begin
                        c = pick_pattern_byte();
                    end else if (r < 68) begin
                        c = " ";
                    end else if (r < 75) begin
                        c = (r < 72) ? "-" : ".";
                    end else if (r < 85) begin
                        c = NEWLINE;
                    end else begin
                        c = t_char'($urandom_range(255));
                    end
                    queue_byte(c, r >= 97);
                    queued++;
                end
            end
            wait_drained();
        end

        // back-pressure: a match on every byte but each ninth (a space) while the output holds off
        apply_config(64'hFFFF_FFFF_FFFF_FF61, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1,
                     1'b1, 1'b0, 1'b0);
        for (int i = 0; i < 80; i++) begin
            queue_byte((i % 9 == 8) ? t_char'(" ") : LOWER_A, 1'b0);
        end
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        wait_drained();

        $display("summary: %0d text bytes under %0d register settings, %0d results checked, %0d mismatches",
                 bytes_accepted, settings_used, results_checked, mismatch_count);
        if (mismatch_count == 0 && match_expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/wwtm_pkg.sv
rtl/whole_word_text_matcher.sv
tb/whole_word_text_matcher_test.sv
